// ===== rtl/core/bpc_pkg.sv =====
// Shared types, register indexes and helpers for the barometric compensation pipeline.
// No dependencies; imported by bpc_div and barometric_pressure_compensation.
package bpc_pkg;

    // Datapath word width of the compensation arithmetic
    localparam int DIV_W = 32;

    // Configuration register indexes
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    // Constants of the published compensation
    localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
    localparam logic signed [31:0] P_COEF_SQ   = 32'sd3038;
    localparam logic signed [31:0] P_COEF_LIN  = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET    = 32'sd3791;
    localparam logic [31:0]        B7_SCALE    = 32'd50000;
    localparam logic [31:0]        B7_TOP      = 32'h8000_0000;
    localparam logic signed [31:0] B4_OFFSET   = 32'sd32768;
    localparam logic signed [31:0] T_MAX       = 32'sd32767;
    localparam logic signed [31:0] T_MIN       = -32'sd32768;
    localparam logic signed [31:0] P_MAX       = 32'sd4194303;

    typedef logic signed [31:0] s32_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [21:0]        pressure_pa;
        logic               divide_error;
    } result_t;

    // Signed divide by 2^k, truncating toward zero
    function automatic s32_t sdiv_p2(input s32_t a, input logic [4:0] k);
        logic [31:0] bias;
        bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        return (a + $signed(bias)) >>> k;
    endfunction

endpackage

// ===== rtl/core/bpc_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg for the word width.
module bpc_div #(
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [bpc_pkg::DIV_W-1:0] num,
    input  logic [bpc_pkg::DIV_W-1:0] den,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_valid,
    output logic [bpc_pkg::DIV_W-1:0] quo,
    output logic [SIDE_W-1:0]         side_out
);
    import bpc_pkg::*;

    localparam int W = DIV_W;

    logic [W-1:0]      rem_reg  [W];
    logic [W-1:0]      quo_reg  [W];
    logic [W-1:0]      den_reg  [W];
    logic [SIDE_W-1:0] side_reg [W];
    logic [W-1:0]      valid_reg;

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic [W-1:0]      rem_prev;
        logic [W-1:0]      quo_prev;
        logic [W-1:0]      den_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              valid_prev;
        logic [W:0]        trial;
        logic [W:0]        diff;
        logic              ge;
        logic [W-1:0]      rem_next;
        logic [W-1:0]      quo_next;

        if (g == 0) begin : g_first
            assign rem_prev   = '0;
            assign quo_prev   = num;
            assign den_prev   = den;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end else begin : g_rest
            assign rem_prev   = rem_reg[g-1];
            assign quo_prev   = quo_reg[g-1];
            assign den_prev   = den_reg[g-1];
            assign side_prev  = side_reg[g-1];
            assign valid_prev = valid_reg[g-1];
        end

        // shift in next dividend bit, subtract when it fits
        always_comb
        begin
            trial    = {rem_prev, quo_prev[W-1]};
            diff     = trial - {1'b0, den_prev};
            ge       = (trial >= {1'b0, den_prev});
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_prev[W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                quo_reg[g]  <= quo_next;
                den_reg[g]  <= den_prev;
                side_reg[g] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign quo       = quo_reg[W-1];
    assign side_out  = side_reg[W-1];

endmodule

// ===== rtl/core/barometric_pressure_compensation.sv =====
// Barometric temperature and pressure compensation, integer scheme, fully pipelined.
// Depends on bpc_pkg and bpc_div.
//
// One raw temperature/pressure item is accepted per clock while the result is not
// stalled. Each item passes 78 register stages (14 arithmetic stages plus two
// 32-stage dividers, one for the temperature term X2 and one for the pressure
// quotient). While a valid result is stalled the whole pipeline holds.
// Calibration registers are write-only and take a write every cycle (cfg_ready is
// always high); write them only while idle.
module barometric_pressure_compensation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  bpc_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output bpc_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import bpc_pkg::*;

    // configuration registers
    logic [31:0] cal_ac1_ac2_reg, cal_ac3_ac4_reg, cal_ac5_ac6_reg;
    logic [31:0] cal_b1_b2_reg, cal_mc_md_reg;
    logic [1:0]  oversampling_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_ac1_ac2_reg  <= '0;
            cal_ac3_ac4_reg  <= '0;
            cal_ac5_ac6_reg  <= '0;
            cal_b1_b2_reg    <= '0;
            cal_mc_md_reg    <= '0;
            oversampling_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AC1_AC2: cal_ac1_ac2_reg  <= cfg_data;
                REG_AC3_AC4: cal_ac3_ac4_reg  <= cfg_data;
                REG_AC5_AC6: cal_ac5_ac6_reg  <= cfg_data;
                REG_B1_B2:   cal_b1_b2_reg    <= cfg_data;
                REG_MC_MD:   cal_mc_md_reg    <= cfg_data;
                REG_OSS:     oversampling_reg <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    // coefficient decode
    s32_t ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0] ac4, ac5, ac6;
    logic [1:0]  oss;

    assign ac1 = 32'(signed'(cal_ac1_ac2_reg[31:16]));
    assign ac2 = 32'(signed'(cal_ac1_ac2_reg[15:0]));
    assign ac3 = 32'(signed'(cal_ac3_ac4_reg[31:16]));
    assign ac4 = cal_ac3_ac4_reg[15:0];
    assign ac5 = cal_ac5_ac6_reg[31:16];
    assign ac6 = cal_ac5_ac6_reg[15:0];
    assign b1  = 32'(signed'(cal_b1_b2_reg[31:16]));
    assign b2  = 32'(signed'(cal_b1_b2_reg[15:0]));
    assign mc  = 32'(signed'(cal_mc_md_reg[31:16]));
    assign md  = 32'(signed'(cal_mc_md_reg[15:0]));
    assign oss = oversampling_reg;

    // global advance: hold everything while a result waits
    logic en;
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    // stage 1: (UT - AC6) * AC5
    logic        v1_reg;
    s32_t        m1_reg;
    logic [18:0] up1_reg;
    s32_t        diff1;
    assign diff1 = $signed({16'd0, sample.raw_temperature}) - $signed({16'd0, ac6});

    // stage 2: X1, divisor and numerator magnitudes
    logic        v2_reg;
    s32_t        x1_2_reg;
    logic [18:0] up2_reg;
    logic [31:0] num2_reg, den2_reg;
    logic        neg2_reg, dz2_reg;
    s32_t        x1_2_next, den2_next, num2_next;
    assign x1_2_next = sdiv_p2(m1_reg, 5'd15);
    assign den2_next = x1_2_next + md;
    assign num2_next = mc <<< 11;

    // temperature divider
    localparam int SIDE1_W = 32 + 19 + 2;
    logic               v3;
    logic [31:0]        q3;
    logic [SIDE1_W-1:0] side3;
    s32_t               x1_3;
    logic [18:0]        up3;
    logic               neg3, dz3;

    bpc_div #(.SIDE_W(SIDE1_W)) u_div_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2_reg),
        .num      (num2_reg),
        .den      (den2_reg),
        .side_in  ({x1_2_reg, up2_reg, neg2_reg, dz2_reg}),
        .out_valid(v3),
        .quo      (q3),
        .side_out (side3)
    );
    assign {x1_3, up3, neg3, dz3} = side3;

    // stage 4: B5, T, B6
    logic        v4_reg, dz4_reg;
    s32_t        t4_reg, b6_4_reg;
    logic [18:0] up4_reg;
    s32_t        x2_4, b5_4;
    assign x2_4 = neg3 ? -$signed(q3) : $signed(q3);
    assign b5_4 = x1_3 + x2_4;

    // stage 5: products of B6, saturate T
    logic        v5_reg, dz5_reg;
    logic [15:0] t5_reg;
    s32_t        sqm5_reg, ma5_reg, mb5_reg;
    logic [18:0] up5_reg;
    logic [15:0] t5_next;
    always_comb
    begin
        if (t4_reg > T_MAX)
            t5_next = T_MAX[15:0];
        else if (t4_reg < T_MIN)
            t5_next = T_MIN[15:0];
        else
            t5_next = t4_reg[15:0];
    end

    // stage 6: scale products
    logic        v6_reg, dz6_reg;
    logic [15:0] t6_reg;
    s32_t        sq6_reg, x2a6_reg, x1c6_reg;
    logic [18:0] up6_reg;

    // stage 7: B2 * SQ, B1 * SQ
    logic        v7_reg, dz7_reg;
    logic [15:0] t7_reg;
    s32_t        md7_reg, me7_reg, x2a7_reg, x1c7_reg;
    logic [18:0] up7_reg;

    // stage 8: X3 sums
    logic        v8_reg, dz8_reg;
    logic [15:0] t8_reg;
    s32_t        x3_8_reg, xs8_reg;
    logic [18:0] up8_reg;

    // stage 9: B3 and the B4 factor
    logic        v9_reg, dz9_reg;
    logic [15:0] t9_reg;
    s32_t        b3_9_reg, vv9_reg;
    logic [18:0] up9_reg;
    logic [31:0] b3_shift;
    assign b3_shift = 32'(ac1 <<< 2) + 32'(x3_8_reg);

    // stage 10: B4 and B7
    logic        v10_reg, dz10_reg;
    logic [15:0] t10_reg;
    logic [31:0] b4_10_reg, b7_10_reg;
    logic [31:0] b4_prod;
    assign b4_prod = {16'd0, ac4} * 32'(vv9_reg);

    // pressure divider
    localparam int SIDE2_W = 16 + 3;
    logic               v11;
    logic [31:0]        q11;
    logic [SIDE2_W-1:0] side11;
    logic [15:0]        t11;
    logic               dz11, b4z11, dbl11;
    logic               dbl10;
    assign dbl10 = (b7_10_reg >= B7_TOP);

    bpc_div #(.SIDE_W(SIDE2_W)) u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v10_reg),
        .num      (dbl10 ? b7_10_reg : (b7_10_reg << 1)),
        .den      (b4_10_reg),
        .side_in  ({t10_reg, dz10_reg, (b4_10_reg == 32'd0), dbl10}),
        .out_valid(v11),
        .quo      (q11),
        .side_out (side11)
    );
    assign {t11, dz11, b4z11, dbl11} = side11;

    // stage 12: p and p / 256
    logic        v12_reg, err12_reg;
    logic [15:0] t12_reg;
    s32_t        ps12_reg, x1_12_reg;
    s32_t        ps12_next;
    assign ps12_next = dbl11 ? $signed(q11 << 1) : $signed(q11);

    // stage 13: square and linear term
    logic        v13_reg, err13_reg;
    logic [15:0] t13_reg;
    s32_t        ps13_reg, sqr13_reg, m7_13_reg;

    // stage 14: square times coefficient
    logic        v14_reg, err14_reg;
    logic [15:0] t14_reg;
    s32_t        ps14_reg, m3_14_reg, m7_14_reg;

    // stage 15: correction sum
    logic        v15_reg, err15_reg;
    logic [15:0] t15_reg;
    s32_t        ps15_reg, sum15_reg;

    // stage 16: final pressure, saturate, output register
    logic    result_valid_reg;
    result_t result_reg;
    s32_t    pf;
    result_t result_next;
    assign pf = ps15_reg + sdiv_p2(sum15_reg, 5'd4);
    always_comb
    begin
        result_next.divide_error       = err15_reg;
        result_next.temperature_tenths = err15_reg ? 16'sd0 : $signed(t15_reg);
        if (err15_reg || pf < 0)
            result_next.pressure_pa = '0;
        else if (pf > P_MAX)
            result_next.pressure_pa = P_MAX[21:0];
        else
            result_next.pressure_pa = pf[21:0];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v4_reg <= 1'b0; v5_reg <= 1'b0;
            v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0; v9_reg <= 1'b0;
            v10_reg <= 1'b0; v12_reg <= 1'b0; v13_reg <= 1'b0; v14_reg <= 1'b0;
            v15_reg <= 1'b0; result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= sample_valid;
            v2_reg  <= v1_reg;
            v4_reg  <= v3;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v12_reg <= v11;
            v13_reg <= v12_reg;
            v14_reg <= v13_reg;
            v15_reg <= v14_reg;
            result_valid_reg <= v15_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= diff1 * $signed({16'd0, ac5});
            up1_reg <= sample.raw_pressure;

            x1_2_reg <= x1_2_next;
            up2_reg  <= up1_reg;
            num2_reg <= num2_next[31] ? 32'(-num2_next) : 32'(num2_next);
            den2_reg <= den2_next[31] ? 32'(-den2_next) : 32'(den2_next);
            neg2_reg <= num2_next[31] ^ den2_next[31];
            dz2_reg  <= (den2_next == 32'sd0);

            t4_reg   <= sdiv_p2(b5_4 + 32'sd8, 5'd4);
            b6_4_reg <= b5_4 - B6_OFFSET;
            up4_reg  <= up3;
            dz4_reg  <= dz3;

            sqm5_reg <= b6_4_reg * b6_4_reg;
            ma5_reg  <= ac2 * b6_4_reg;
            mb5_reg  <= ac3 * b6_4_reg;
            t5_reg   <= t5_next;
            up5_reg  <= up4_reg;
            dz5_reg  <= dz4_reg;

            sq6_reg  <= sdiv_p2(sqm5_reg, 5'd12);
            x2a6_reg <= sdiv_p2(ma5_reg, 5'd11);
            x1c6_reg <= sdiv_p2(mb5_reg, 5'd13);
            t6_reg   <= t5_reg;
            up6_reg  <= up5_reg;
            dz6_reg  <= dz5_reg;

            md7_reg  <= b2 * sq6_reg;
            me7_reg  <= b1 * sq6_reg;
            x2a7_reg <= x2a6_reg;
            x1c7_reg <= x1c6_reg;
            t7_reg   <= t6_reg;
            up7_reg  <= up6_reg;
            dz7_reg  <= dz6_reg;

            x3_8_reg <= sdiv_p2(md7_reg, 5'd11) + x2a7_reg;
            xs8_reg  <= x1c7_reg + sdiv_p2(me7_reg, 5'd16);
            t8_reg   <= t7_reg;
            up8_reg  <= up7_reg;
            dz8_reg  <= dz7_reg;

            b3_9_reg <= sdiv_p2($signed(b3_shift << oss) + 32'sd2, 5'd2);
            vv9_reg  <= sdiv_p2(xs8_reg + 32'sd2, 5'd2) + B4_OFFSET;
            t9_reg   <= t8_reg;
            up9_reg  <= up8_reg;
            dz9_reg  <= dz8_reg;

            b4_10_reg <= b4_prod >> 15;
            b7_10_reg <= ({13'd0, up9_reg} - 32'(b3_9_reg)) * (B7_SCALE >> oss);
            t10_reg   <= t9_reg;
            dz10_reg  <= dz9_reg;

            ps12_reg  <= ps12_next;
            x1_12_reg <= sdiv_p2(ps12_next, 5'd8);
            t12_reg   <= t11;
            err12_reg <= dz11 | b4z11;

            sqr13_reg <= x1_12_reg * x1_12_reg;
            m7_13_reg <= P_COEF_LIN * ps12_reg;
            ps13_reg  <= ps12_reg;
            t13_reg   <= t12_reg;
            err13_reg <= err12_reg;

            m3_14_reg <= sqr13_reg * P_COEF_SQ;
            m7_14_reg <= m7_13_reg;
            ps14_reg  <= ps13_reg;
            t14_reg   <= t13_reg;
            err14_reg <= err13_reg;

            sum15_reg <= sdiv_p2(m3_14_reg, 5'd16) + sdiv_p2(m7_14_reg, 5'd16) + P_OFFSET;
            ps15_reg  <= ps14_reg;
            t15_reg   <= t14_reg;
            err15_reg <= err14_reg;

            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== tb/sv/barometric_pressure_compensation_test.sv =====
// Self-checking testbench for barometric_pressure_compensation: random and directed samples,
// calibration sweeps, output stalls. Depends on bpc_pkg and the block's RTL only.
module barometric_pressure_compensation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       sample_valid;
    logic       sample_stall;
    sample_t    sample;
    logic       result_valid;
    logic       result_stall;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    // Calibration copy used for prediction, and expected results in order
    logic [31:0] cal_word [0:5];
    result_t     pending_results [$];
    int          error_count;
    int          quiet_cycles;
    bit          no_idle;
    int          hold_requests;

    barometric_pressure_compensation i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Integer compensation of one sample with the current calibration
    function automatic result_t compensate(input sample_t s);
        result_t     r;
        int          ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
        int          x1, x2, x3, den, b5, t, b6, sq, b3, ps;
        int unsigned ac4, up, oss, b4, b7, p;
        ac1 = $signed(cal_word[REG_AC1_AC2][31:16]);
        ac2 = $signed(cal_word[REG_AC1_AC2][15:0]);
        ac3 = $signed(cal_word[REG_AC3_AC4][31:16]);
        ac4 = cal_word[REG_AC3_AC4][15:0];
        ac5 = int'(cal_word[REG_AC5_AC6][31:16]);
        ac6 = int'(cal_word[REG_AC5_AC6][15:0]);
        b1 = $signed(cal_word[REG_B1_B2][31:16]);
        b2 = $signed(cal_word[REG_B1_B2][15:0]);
        mc = $signed(cal_word[REG_MC_MD][31:16]);
        md = $signed(cal_word[REG_MC_MD][15:0]);
        oss = cal_word[REG_OSS][1:0];
        ut = int'(s.raw_temperature);
        up = s.raw_pressure;
        r = '0;

        // temperature
        x1 = ((ut - ac6) * ac5) / 32768;
        den = x1 + md;
        if (den == 0)
        begin
            r.divide_error = 1'b1;
            return r;
        end
        x2 = (mc * 2048) / den;
        b5 = x1 + x2;
        t = (b5 + 8) / 16;

        // pressure
        b6 = b5 - 4000;
        sq = (b6 * b6) / 4096;
        x1 = (b2 * sq) / 2048;
        x2 = (ac2 * b6) / 2048;
        x3 = x1 + x2;
        b3 = (((ac1 * 4 + x3) << oss) + 2) / 4;
        x1 = (ac3 * b6) / 8192;
        x2 = (b1 * sq) / 65536;
        x3 = (x1 + x2 + 2) / 4;
        b4 = (ac4 * int'(unsigned'(x3 + 32768))) >> 15;
        if (b4 == 0)
        begin
            r.divide_error = 1'b1;
            return r;
        end
        b7 = (up - unsigned'(b3)) * (32'd50000 >> oss);
        if (b7 < 32'h8000_0000)
            p = (b7 * 2) / b4;
        else
            p = (b7 / b4) * 2;
        ps = signed'(p);
        x1 = ps / 256;
        x1 = x1 * x1;
        x1 = (x1 * 3038) / 65536;
        x2 = (-7357 * ps) / 65536;
        ps = ps + (x1 + x2 + 3791) / 16;

        // saturation
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        if (ps < 0)
            ps = 0;
        if (ps > 4194303)
            ps = 4194303;
        r.temperature_tenths = t[15:0];
        r.pressure_pa = ps[21:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Register write; cfg_valid stays high until cfg_idle
    task automatic write_cal(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_OSS)
            cal_word[idx] = {30'd0, data[1:0]};
        else if (idx < 3'd5)
            cal_word[idx] = data;
    endtask

    task automatic cfg_idle();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_cal(input logic [31:0] w0, w1, w2, w3, w4, input logic [31:0] os);
        write_cal(REG_AC1_AC2, w0);
        write_cal(REG_AC3_AC4, w1);
        write_cal(REG_AC5_AC6, w2);
        write_cal(REG_B1_B2, w3);
        write_cal(REG_MC_MD, w4);
        write_cal(REG_OSS, os);
        cfg_idle();
    endtask

    // Send one item, idling beforehand now and then
    task automatic send_sample(input logic [15:0] ut, input logic [18:0] up);
        sample_t s;
        s.raw_temperature = ut;
        s.raw_pressure = up;
        if (!no_idle && $urandom_range(99) < 13)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        pending_results.push_back(compensate(s));
    endtask

    // Wait until every expected result has come, then let the pipe drain
    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_random(input int count, input bit typical);
        repeat (count)
        begin
            if (typical)
                send_sample(16'($urandom_range(20000, 36000)), 19'($urandom_range(20000, 400000)));
            else
                send_sample(16'($urandom), 19'($urandom));
        end
    endtask

    // Typical sensor calibration, field extremes and ignored writes
    task automatic test_typical();
        load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                 {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 32'hFFFF_FFFC);
        write_cal(3'd6, 32'hDEAD_BEEF);
        write_cal(3'd7, 32'h1234_5678);
        cfg_idle();
        send_sample(16'd27898, 19'd23843);
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'hFFFF, 19'd0);
        send_sample(16'h5555, 19'h2AAAA);
        send_sample(16'hAAAA, 19'h55555);
        send_random(150, 1'b1);
        drain();
    endtask

    // Zero temperature divisor, then zero pressure divisor
    task automatic test_divide_by_zero();
        load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h0000_5A71, 32'h182E_0004, 32'hDDF9_0000, 32'd1);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_random(20, 1'b0);
        drain();
        load_cal(32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34, 32'd2);
        send_sample(16'd27898, 19'd23843);
        send_random(20, 1'b0);
        drain();
    endtask

    // All-ones and sign-bit calibration extremes
    task automatic test_extremes();
        load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0001, 32'd3);
        send_random(100, 1'b0);
        drain();
        load_cal(32'h8000_7FFF, 32'h7FFF_0001, 32'hFFFF_0000, 32'h8000_7FFF, 32'h7FFF_8000, 32'd0);
        send_random(100, 1'b0);
        drain();
    endtask

    // Random calibration sets at every oversampling value, no idling in one
    task automatic test_random_cal();
        for (int os = 0; os < 4; os++)
        begin
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom, {$urandom} << 2 | os);
            no_idle = (os == 2);
            send_random(150, 1'b0);
            drain();
            load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                     {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, os);
            send_random(150, 1'b1);
            drain();
        end
        no_idle = 1'b0;
    endtask

    // Receiver holds off while items keep coming
    task automatic test_backpressure();
        load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34, 32'd1);
        hold_requests++;
        send_random(250, 1'b1);
        drain();
    endtask

    // Output stall: random, with a long hold on request
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !no_idle && ($urandom_range(99) < 13);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                if (result.temperature_tenths !== want.temperature_tenths)
                    report_mismatch("temperature_tenths", result.temperature_tenths,
                                    want.temperature_tenths);
                if (result.pressure_pa !== want.pressure_pa)
                    report_mismatch("pressure_pa", result.pressure_pa, want.pressure_pa);
                if (result.divide_error !== want.divide_error)
                    report_mismatch("divide_error", result.divide_error, want.divide_error);
            end
        end
    end

    // Watchdog on cycles with no accepted item on any channel
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        hold_requests = 0;
        for (int i = 0; i < 6; i++)
            cal_word[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: zero divisor everywhere
        send_sample(16'd1000, 19'd1000);
        drain();
        test_typical();
        test_divide_by_zero();
        test_extremes();
        test_random_cal();
        test_backpressure();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
